// ----- rtl/dtvr_pkg.sv -----
// Package: shared constants, command/status structs and cosine table math.
package dtvr_pkg;

  localparam int unsigned COS_TABLE_DEPTH_DEF = 1024;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned FIT_W = 48;
  localparam int unsigned IN_DATA_W = 232;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned ADDR_W = 3;
  localparam logic [7:0] AMP_RESET = 8'd10;
  localparam logic [0:0] REG_AMPLITUDE = 1'b0;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned CosDiv [7] = '{2, 12, 30, 56, 90, 132, 182};
  localparam longint unsigned SinDiv [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef struct packed {
    logic load;
    logic mul;
    logic trial;
    logic square;
    logic acc;
  } dtvr_cmd_t;

  typedef struct packed {
    logic out_free;
  } dtvr_status_t;

  // cos (odd = 0) or sin (odd = 1) of theta in Q2.30, result in Q2.14
  function automatic logic [15:0] series_q14(longint unsigned theta, bit odd);
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint unsigned rnd;
    x2 = (theta * theta) >> 30;
    term = odd ? theta : ONE_Q30;
    sum = longint'(term);
    for (int i = 0; i < 7; i++) begin
      if (odd) term = ((term * x2) >> 30) / SinDiv[i];
      else     term = ((term * x2) >> 30) / CosDiv[i];
      if ((i % 2) == 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    rnd = (longint'(sum) + 32768) >> 16;
    return rnd[15:0];
  endfunction

endpackage

// ----- rtl/dtvr_ctrl.sv -----
// Controller: sequences one item through the datapath stages.
module dtvr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  dtvr_pkg::dtvr_status_t status,
  output dtvr_pkg::dtvr_cmd_t   cmd
);
  import dtvr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_TRIAL  = 5'b00100,
    ST_SQUARE = 5'b01000,
    ST_ACC    = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_TRIAL;
      end
      ST_TRIAL: begin
        cmd.trial = 1'b1;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (status.out_free) begin
          cmd.acc = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_acc_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> status.out_free) else $error("result written with no room");
  a_load_then_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.mul) else $error("load not followed by multiply");
  a_mul_chain: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> cmd.trial ##1 cmd.square) else $error("stage order broken");

endmodule

// ----- rtl/dtvr_datapath.sv -----
// Datapath: mutation, crossover, Rastrigin term, accumulator, output register.
module dtvr_datapath #(
  parameter int unsigned COS_TABLE_DEPTH = dtvr_pkg::COS_TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [dtvr_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  output logic [dtvr_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_wr,
  input  logic [7:0]                        cfg_amp,
  output logic [7:0]                        amp,
  input  dtvr_pkg::dtvr_cmd_t               cmd,
  output dtvr_pkg::dtvr_status_t            status
);
  import dtvr_pkg::*;

  localparam int unsigned IDX_W = $clog2(COS_TABLE_DEPTH);

  typedef logic signed [15:0] rom_t [COS_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    int unsigned num;
    int unsigned quad;
    longint unsigned rem;
    longint unsigned theta;
    logic [15:0] v;
    for (int unsigned k = 0; k < COS_TABLE_DEPTH; k++) begin
      num = 4 * k;
      quad = num / COS_TABLE_DEPTH;
      rem = longint'(num % COS_TABLE_DEPTH);
      theta = rem * HALF_PI_Q30 / COS_TABLE_DEPTH;
      unique case (quad % 4)
        0:       v = series_q14(theta, 1'b0);
        1:       v = -series_q14(theta, 1'b1);
        2:       v = -series_q14(theta, 1'b0);
        default: v = series_q14(theta, 1'b1);
      endcase
      r[k] = signed'(v);
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  // input item registers
  logic signed [31:0] x_q, pb_q, r1_q, r2_q;
  logic [15:0] draw_q;
  logic        forced_q, last_q;
  logic [16:0] cr_q, f_q;
  logic [47:0] pfit_q;

  // stage registers
  logic [50:0] prod_q;
  logic        neg_q, cross_q;
  logic signed [31:0] y_q;
  logic [63:0] sq_q;
  logic signed [15:0] cos_q;
  logic [47:0] acc;

  logic [31:0] trial_o;
  logic [47:0] fit_o;
  logic        accept_o;

  always_ff @(posedge clk) begin
    if (rst) amp <= AMP_RESET;
    else if (cfg_wr) amp <= cfg_amp;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_q      <= s_tdata[31:0];
      pb_q     <= s_tdata[63:32];
      r1_q     <= s_tdata[95:64];
      r2_q     <= s_tdata[127:96];
      draw_q   <= s_tdata[143:128];
      forced_q <= s_tdata[144];
      cr_q     <= s_tdata[161:145];
      f_q      <= s_tdata[178:162];
      pfit_q   <= s_tdata[226:179];
      last_q   <= s_tlast;
    end
  end

  // mutation difference and scale
  logic signed [34:0] s_sum;
  logic [33:0] s_mag;
  logic [16:0] cr_c, f_c;
  always_comb begin
    s_sum = (35'(pb_q) - 35'(x_q)) + (35'(r1_q) - 35'(r2_q));
    s_mag = s_sum[34] ? 34'(-s_sum) : 34'(s_sum);
    cr_c = (cr_q > ONE_Q16) ? ONE_Q16 : cr_q;
    f_c  = (f_q  > ONE_Q16) ? ONE_Q16 : f_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q  <= 51'(s_mag) * 51'(f_c);
      neg_q   <= s_sum[34];
      cross_q <= (17'(draw_q) <= cr_c) || forced_q;
    end
  end

  // round half away, apply, saturate
  logic [51:0] rnd;
  logic signed [36:0] y_sum;
  logic signed [31:0] y_sat;
  always_comb begin
    rnd = 52'(prod_q) + 52'd32768;
    y_sum = neg_q ? (37'(x_q) - signed'(37'(rnd[51:16])))
                  : (37'(x_q) + signed'(37'(rnd[51:16])));
    if (y_sum > 37'sd2147483647)       y_sat = 32'sh7FFFFFFF;
    else if (y_sum < -37'sd2147483648) y_sat = 32'sh80000000;
    else                               y_sat = y_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.trial) y_q <= cross_q ? y_sat : x_q;
  end

  // square and cosine lookup
  logic [31:0] y_mag;
  logic [36:0] idx_prod;
  logic [IDX_W-1:0] idx;
  always_comb begin
    y_mag = y_q[31] ? 32'(-y_q) : 32'(y_q);
    idx_prod = 37'(y_q[23:0]) * 37'(COS_TABLE_DEPTH);
    idx = idx_prod[24 +: IDX_W];
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_q  <= 64'(y_mag) * 64'(y_mag);
      cos_q <= COS_ROM[idx];
    end
  end

  // Rastrigin term and saturating sum
  logic [64:0] sq_rnd;
  logic [16:0] one_minus;
  logic [34:0] amp_term;
  logic [48:0] acc_sum;
  logic [47:0] acc_sat;
  always_comb begin
    sq_rnd = 65'(sq_q) + 65'h800000;
    one_minus = 17'(17'sd16384 - 17'(cos_q));
    amp_term = 35'(amp) * 35'(one_minus) << 10;
    acc_sum = 49'(acc) + 49'(sq_rnd[64:24]) + 49'(amp_term);
    acc_sat = acc_sum[48] ? {FIT_W{1'b1}} : acc_sum[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) acc <= '0;
    else if (cmd.acc) acc <= last_q ? '0 : acc_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.acc) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      trial_o  <= y_q;
      fit_o    <= last_q ? acc_sat : '0;
      accept_o <= last_q && (acc_sat <= pfit_q);
      m_tlast  <= last_q;
    end
  end

  assign m_tdata = {7'd0, accept_o, fit_o, trial_o};
  assign status.out_free = !m_tvalid || m_tready;

  a_valid_from_acc: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.acc)) else $error("result without write");
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.acc && last_q) |=> (acc == '0)) else $error("sum not cleared");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> (!m_tvalid || m_tready)) else $error("pending result lost");

endmodule

// ----- rtl/de_trial_vector_rastrigin.sv -----
// Top level: JADE trial vector element with Rastrigin fitness accumulation.
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata: vector elements, draw, rates, parent fitness
//                                  tlast: last_element
// m_*      out  tvalid/tready      tdata: trial value, fitness, accept; tlast: result_last
// apb      in   psel/penable       reg 0 @ 0x0: rastrigin_amplitude
//
// Each item passes these steps from accept to result register: capture, scaled
// difference multiply, round/crossover, square plus cosine table read, sum.
// The next item is accepted once the previous one has left the sum stage,
// so only one item is in flight at a time, under the single shared sequencer.
// A stalled output holds in its register; the sum stage waits for room.
// Synchronous reset clears the sequencer, fitness sum and amplitude (to 10);
// the cosine table is a constant ROM, needs no fill.
module de_trial_vector_rastrigin #(
  parameter int unsigned COS_TABLE_DEPTH = dtvr_pkg::COS_TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [31:0] parent_value, [63:32] best_value, [95:64] diff_first_value,
  // [127:96] diff_second_value, [143:128] uniform_draw, [144] forced_dimension,
  // [161:145] crossover_rate, [178:162] scale_factor, [226:179] parent_fitness
  input  logic [dtvr_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] trial_value, [79:32] trial_fitness, [80] accept_trial
  output logic [dtvr_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dtvr_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import dtvr_pkg::*;

  dtvr_cmd_t    cmd;
  dtvr_status_t status;
  logic [7:0]   amp;
  logic         cfg_wr;

  assign pready = 1'b1;
  // register index is the word address; only index 0 exists
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_AMPLITUDE);
  assign prdata = (paddr[2] == REG_AMPLITUDE) ? {24'd0, amp} : 32'd0;

  dtvr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dtvr_datapath #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_wr   (cfg_wr),
    .cfg_amp  (pwdata[7:0]),
    .amp      (amp),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ----- verif/tb_de_trial_vector_rastrigin.sv -----
// Testbench for de_trial_vector_rastrigin: trial element and Rastrigin fitness checks.
//
// Items go in on the s_* stream and results come back on the m_* stream. A small
// scoreboard recomputes each trial element with its own fitness sum and cosine
// table, then compares every returned result with the oldest one still waiting.
// The run steps through several amplitude settings and idling phases. It also has
// one very long vector that drives the fitness sum into saturation.
module tb_de_trial_vector_rastrigin;
  import dtvr_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [31:0] x, pb, r1, r2;
    logic [15:0] draw;
    logic        forced;
    logic [16:0] cr, f;
    logic [47:0] pfit;
    logic        last;
  } dim_item_t;

  typedef struct {
    logic [31:0] trial;
    logic [47:0] fit;
    logic        accept;
    logic        last;
  } trial_res_t;

  // Scoreboard: own copy of the fitness sum, the amplitude and the cosine table.
  class trial_book;
    trial_res_t  waiting[$];
    int          cos_q14[COS_TABLE_DEPTH_DEF];
    longint unsigned fit_sum;
    logic [7:0]  amplitude;
    int          errors, results;

    function new();
      longint unsigned theta, rem;
      int quad;
      for (int k = 0; k < COS_TABLE_DEPTH_DEF; k++) begin
        quad = (4 * k) / COS_TABLE_DEPTH_DEF;
        rem = (4 * k) % COS_TABLE_DEPTH_DEF;
        theta = rem * HALF_PI_Q30 / COS_TABLE_DEPTH_DEF;
        case (quad)
          0: cos_q14[k] = taylor_q14(theta, 0);
          1: cos_q14[k] = -taylor_q14(theta, 1);
          2: cos_q14[k] = -taylor_q14(theta, 0);
          default: cos_q14[k] = taylor_q14(theta, 1);
        endcase
      end
      fit_sum = 0;
      amplitude = AMP_RESET;
    endfunction

    // cos (odd=0) or sin (odd=1) of a Q2.30 angle, clamped, rounded to Q2.14
    function int taylor_q14(longint unsigned theta, int odd);
      longint unsigned sq, t, d;
      longint acc;
      sq = (theta * theta) >> 30;
      t = odd ? theta : ONE_Q30;
      acc = longint'(t);
      for (int i = 1; i <= 7; i++) begin
        d = longint'((2 * i - 1 + odd) * (2 * i + odd));
        t = ((t * sq) >> 30) / d;
        if (i % 2) acc -= longint'(t);
        else acc += longint'(t);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      return int'((longint'(acc) + 32768) >>> 16);
    endfunction

    function void predict_trial(dim_item_t it);
      longint y, s, am, stp, mag, pen;
      longint unsigned cr, f;
      int c;
      trial_res_t r;
      cr = (it.cr > ONE_Q16) ? ONE_Q16 : it.cr;
      f = (it.f > ONE_Q16) ? ONE_Q16 : it.f;
      y = it.x;
      if (it.draw <= cr || it.forced) begin
        s = longint'(it.pb) - it.x + longint'(it.r1) - it.r2;
        am = (s < 0) ? -s : s;
        stp = (am * longint'(f) + 32768) >>> 16;  // ties away from zero
        y = (s < 0) ? it.x - stp : it.x + stp;
        if (y > 64'sd2147483647) y = 64'sd2147483647;
        if (y < -64'sd2147483648) y = -64'sd2147483648;
      end
      mag = (y < 0) ? -y : y;
      c = cos_q14[(y & 64'hFFFFFF) >> 14];
      pen = longint'(amplitude) * (16384 - c);
      fit_sum += ((mag * mag + 64'h800000) >> 24) + (pen << 10);
      if (fit_sum > 64'hFFFF_FFFF_FFFF) fit_sum = 64'hFFFF_FFFF_FFFF;
      r.trial = y[31:0];
      r.last = it.last;
      r.fit = it.last ? fit_sum[47:0] : '0;
      r.accept = it.last && (fit_sum <= it.pfit);
      if (it.last) fit_sum = 0;
      waiting = {waiting, r};
    endfunction

    function void check_trial(trial_res_t a);
      trial_res_t e;
      results++;
      if (waiting.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result trial=%h fit=%h", a.trial, a.fit);
        return;
      end
      e = waiting.pop_front();
      if (a.trial !== e.trial || a.fit !== e.fit || a.accept !== e.accept ||
          a.last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp trial=%h fit=%h acc=%b last=%b, got %h %h %b %b",
                   results, e.trial, e.fit, e.accept, e.last,
                   a.trial, a.fit, a.accept, a.last);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tlast = 0, m_tready = 0;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic s_tready, m_tvalid, m_tlast, pready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [31:0] prdata;

  trial_book book = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_reqs = 0, hold_seen = 0, hold_left = 0;
  int cycles = 0, sent = 0, vectors = 0;

  de_trial_vector_rastrigin dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall, plus a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    trial_res_t r;
    if (!rst && m_tvalid && m_tready) begin
      r.trial = m_tdata[31:0];
      r.fit = m_tdata[79:32];
      r.accept = m_tdata[80];
      r.last = m_tlast;
      book.check_trial(r);
    end
  end

  task automatic send_dim(dim_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, it.pfit, it.f, it.cr, it.forced, it.draw, it.r2, it.r1, it.pb, it.x};
    s_tlast <= it.last;
    do @(posedge clk); while (!s_tready);
    book.predict_trial(it);
    sent++;
    if (it.last) vectors++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.waiting.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_amplitude(logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(REG_AMPLITUDE) << 2;
    pwdata <= {24'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    book.amplitude = v;
  endtask

  function automatic dim_item_t mk(logic [31:0] x, pb, r1, r2, logic [15:0] draw,
                                   logic forced, logic [16:0] cr, f,
                                   logic [47:0] pfit, logic last);
    dim_item_t it;
    it.x = x; it.pb = pb; it.r1 = r1; it.r2 = r2;
    it.draw = draw; it.forced = forced; it.cr = cr; it.f = f;
    it.pfit = pfit; it.last = last;
    return it;
  endfunction

  // Values spread over all magnitudes, from tiny fractions to full scale.
  function automatic logic [31:0] rand_val();
    int v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  function automatic dim_item_t rand_dim(logic last);
    dim_item_t it;
    it = mk(rand_val(), rand_val(), rand_val(), rand_val(), 16'($urandom), 0,
            17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)), '0, last);
    it.forced = ($urandom_range(9) == 0);
    if ($urandom_range(7) == 0) it.cr = 17'($urandom);  // above one now and then
    if ($urandom_range(7) == 0) it.f = 17'($urandom);
    it.pfit = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
    return it;
  endfunction

  task automatic rand_vectors(int n_items);
    int len;
    while (n_items > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_dim(rand_dim(i == len - 1));
      n_items -= len;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, crossover paths, rounding ties, rates above one.
    send_dim(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_dim(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0, 0,
                17'd65536, 17'd65536, 0, 0));
    send_dim(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0, 0,
                17'd65536, 17'd65536, 0, 1));
    send_dim(mk(32'h01800000, 32'h02000000, 32'h00000000, 32'h00000001, 16'hFFFF, 0,
                17'h1FFFF, 17'h1FFFF, 48'hFFFFFFFFFFFF, 1));
    send_dim(mk(32'h00400000, 32'hFF000000, 32'h12345678, 32'h00000000, 16'hFFFF, 1,
                17'd0, 17'd40000, 0, 0));
    send_dim(mk(32'hFFC00000, 32'h12345678, 32'h0, 32'h0, 16'hFFFF, 0,
                17'd65535, 17'd65536, 0, 0));
    send_dim(mk(32'h00000000, 32'h00000001, 32'h0, 32'h0, 16'd100, 0,
                17'd100, 17'd32768, 0, 0));
    send_dim(mk(32'h00000000, 32'hFFFFFFFF, 32'h0, 32'h0, 16'd0, 0,
                17'd0, 17'd32768, 48'hFFFFFFFFFFFF, 1));
    send_dim(mk(32'h00800000, 32'h0, 32'h0, 32'h0, 16'hFFFF, 0, 0, 0,
                48'h0, 1));
    send_dim(mk(32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 16'hFFFF, 0, 0, 0,
                48'hFFFFFFFFFFFF, 1));
    for (int i = 0; i < 8; i++) send_dim(rand_dim(i == 7));
    drain();

    // Amplitude extremes, each with random vectors under a different idling mix.
    write_amplitude(8'd0);
    send_idle_pct = 71; recv_stall_pct = 0;
    rand_vectors(60);
    drain();

    write_amplitude(8'd255);
    send_idle_pct = 0; recv_stall_pct = 71;
    rand_vectors(60);
    drain();

    // Long vector of full-scale elements pushes the fitness sum into saturation.
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 1030; i++)
      send_dim(mk(32'h80000000, 0, 0, 0, 16'hFFFF, 0, 0, 0,
                  48'({$urandom, $urandom}), i == 1029));
    drain();

    write_amplitude(8'($urandom_range(1, 254)));
    send_idle_pct = 16; recv_stall_pct = 16;
    rand_vectors(60);

    // Receiver holds off while items keep coming, so the block backs up.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_reqs++;
    rand_vectors(20);
    drain();

    write_amplitude(AMP_RESET);
    send_idle_pct = 30; recv_stall_pct = 30;
    rand_vectors(60);
    drain();

    $display("covered %0d items in %0d vectors, 4 amplitude settings, saturated sum",
             sent, vectors);
    $display("mismatches: %0d over %0d results", book.errors, book.results);
    if (book.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dtvr_pkg.sv
rtl/dtvr_ctrl.sv
rtl/dtvr_datapath.sv
rtl/de_trial_vector_rastrigin.sv
verif/tb_de_trial_vector_rastrigin.sv
